// ===== src/egd_pkg.sv =====
// egd_pkg: shared constants for the elias gamma / delta decoder
// mode codes, status codes, configuration register indexes and limits
// no dependencies
package egd_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BITS  = 1'd1;
    localparam int unsigned CFG_DATA_W = 7;

    // code mode encodings
    localparam logic [1:0] MODE_GAMMA      = 2'd0;
    localparam logic [1:0] MODE_DELTA_ZERO = 2'd1;
    localparam logic [1:0] MODE_DELTA_NZ   = 2'd2;

    // result status
    localparam logic ST_OK        = 1'b0;
    localparam logic ST_TOO_LARGE = 1'b1;

    // limits
    localparam logic [6:0] LEN_LIMIT = 7'd8;
    localparam logic [6:0] RUN_MAX   = 7'd127;
    localparam logic [6:0] MAX_BITS_RESET = 7'd64;

endpackage

// ===== src/elias_gamma_delta_decoder.sv =====
// elias_gamma_delta_decoder: bit-serial elias gamma / elias delta decoder
// one input register, one pass of decode logic, one result register
// depends on egd_pkg
//
//  channel   signals                          payload            flow
//  --------  -------------------------------  -----------------  ----------
//  input     in_valid / in_stall              code_bit           1 bit/clk unless stalled
//  output    out_valid / out_stall            value, status      <=1 per bit
//  config    cfg_we, cfg_index, cfg_data      code_mode,max_bits write only
//
// each code bit is taken into the input register, then decoded against the
// phase / run / tail / accumulator registers; a bit can be accepted every
// cycle unless in_stall is high, and a code's result is registered when its
// last bit leaves the input register. in_stall rises only while a bit waits
// in the input register and the result register holds a stalled word.
// rst_n (async, active low) clears the decode state, sets gamma mode and a
// 64 bit limit; a config write also drops any partly decoded code.
module elias_gamma_delta_decoder #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 code_bit,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [VALUE_WIDTH-1:0]               value,
    output logic                                 status,
    // configuration
    input  logic                                 cfg_we,
    input  logic [egd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [egd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam logic [6:0] VW7 = 7'(VALUE_WIDTH);

    // decode phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,   // counting prefix zeros
        PH_LEN  = 2'd1,   // length tail (delta) or value tail (gamma)
        PH_VAL  = 2'd2    // delta value tail
    } phase_t;

    // configuration registers
    logic [1:0]             code_mode_reg;
    logic [6:0]             max_bits_reg;

    // input register
    logic                   s1_valid_reg;
    logic                   s1_bit_reg;

    // decode state
    phase_t                 phase_reg, phase_next;
    logic [6:0]             zero_run_reg, zero_run_next;
    logic [7:0]             length_msb_reg, length_msb_next;
    logic [7:0]             tail_left_reg, tail_left_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    // result register
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   status_reg;

    // handshake
    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // effective mode and width
    logic [1:0] mode;
    logic [6:0] eff;
    logic [VALUE_WIDTH-1:0] eff_mask;

    assign mode = (code_mode_reg == egd_pkg::MODE_DELTA_ZERO ||
                   code_mode_reg == egd_pkg::MODE_DELTA_NZ) ? code_mode_reg
                                                            : egd_pkg::MODE_GAMMA;
    assign eff = (max_bits_reg == 7'd0) ? 7'd1
               : (max_bits_reg > VW7)  ? VW7 : max_bits_reg;
    // shifting by the full width gives zero, so eff == VALUE_WIDTH is all ones
    assign eff_mask = ~({VALUE_WIDTH{1'b1}} << eff);

    // decode one bit
    logic                   emit;
    logic [VALUE_WIDTH-1:0] emit_val;
    logic                   emit_st;
    logic                   do_start;
    logic [7:0]             sv_msb;
    logic [VALUE_WIDTH-1:0] acc_sh;
    logic [VALUE_WIDTH-1:0] acc_v;
    logic [7:0]             tail_dec;
    logic [7:0]             eff8;
    logic                   top;
    logic [6:0]             lim;

    assign acc_sh   = {acc_reg[VALUE_WIDTH-2:0], s1_bit_reg};
    assign tail_dec = tail_left_reg - {7'd0, (tail_left_reg != 8'd0)};
    assign eff8     = {1'b0, eff};
    assign top      = (mode == egd_pkg::MODE_DELTA_ZERO) && (length_msb_reg == eff8);
    assign acc_v    = top ? (acc_reg | VALUE_WIDTH'(s1_bit_reg)) : acc_sh;
    assign lim      = (mode == egd_pkg::MODE_GAMMA) ? eff : egd_pkg::LEN_LIMIT;

    always_comb
    begin
        phase_next      = phase_reg;
        zero_run_next   = zero_run_reg;
        length_msb_next = length_msb_reg;
        tail_left_next  = tail_left_reg;
        acc_next        = acc_reg;
        emit            = 1'b0;
        emit_val        = '0;
        emit_st         = egd_pkg::ST_OK;
        do_start        = 1'b0;
        sv_msb          = 8'd0;

        unique case (phase_reg)
            PH_LEN:
            begin
                acc_next       = acc_sh;
                tail_left_next = tail_dec;
                if (tail_dec == 8'd0)
                begin
                    if (mode == egd_pkg::MODE_GAMMA)
                    begin
                        emit     = 1'b1;
                        emit_val = acc_sh;
                    end
                    else
                    begin
                        do_start = 1'b1;
                        sv_msb   = acc_sh[7:0] - 8'd1;
                    end
                end
            end
            PH_VAL:
            begin
                acc_next       = acc_v;
                tail_left_next = tail_dec;
                if (tail_dec == 8'd0)
                begin
                    emit = 1'b1;
                    if (top)
                    begin
                        // top code: all tail bits must be zero
                        if (acc_v != '0)
                            emit_st = egd_pkg::ST_TOO_LARGE;
                        else
                            emit_val = eff_mask;
                    end
                    else if (mode == egd_pkg::MODE_DELTA_ZERO)
                        emit_val = acc_v - VALUE_WIDTH'(1);
                    else
                        emit_val = acc_v;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (!s1_bit_reg)
                begin
                    if (zero_run_reg < egd_pkg::RUN_MAX)
                        zero_run_next = zero_run_reg + 7'd1;
                end
                else
                begin
                    zero_run_next = 7'd0;
                    if (zero_run_reg >= lim)
                    begin
                        emit    = 1'b1;
                        emit_st = egd_pkg::ST_TOO_LARGE;
                    end
                    else if (zero_run_reg == 7'd0)
                    begin
                        if (mode == egd_pkg::MODE_GAMMA)
                        begin
                            emit     = 1'b1;
                            emit_val = VALUE_WIDTH'(1);
                        end
                        else
                            do_start = 1'b1;
                    end
                    else
                    begin
                        acc_next        = VALUE_WIDTH'(1);
                        length_msb_next = {1'b0, zero_run_reg};
                        tail_left_next  = {1'b0, zero_run_reg};
                        phase_next      = PH_LEN;
                    end
                end
            end
        endcase

        // delta: msb known, start the value tail or finish now
        if (do_start)
        begin
            if (mode == egd_pkg::MODE_DELTA_ZERO)
            begin
                if (sv_msb > eff8)
                begin
                    emit    = 1'b1;
                    emit_st = egd_pkg::ST_TOO_LARGE;
                end
                else if (sv_msb == 8'd0)
                    emit = 1'b1;
                else
                begin
                    acc_next        = (sv_msb == eff8) ? '0 : VALUE_WIDTH'(1);
                    length_msb_next = sv_msb;
                    tail_left_next  = sv_msb;
                    phase_next      = PH_VAL;
                end
            end
            else
            begin
                if (sv_msb >= eff8)
                begin
                    emit    = 1'b1;
                    emit_st = egd_pkg::ST_TOO_LARGE;
                end
                else if (sv_msb == 8'd0)
                begin
                    emit     = 1'b1;
                    emit_val = VALUE_WIDTH'(1);
                end
                else
                begin
                    acc_next        = VALUE_WIDTH'(1);
                    length_msb_next = sv_msb;
                    tail_left_next  = sv_msb;
                    phase_next      = PH_VAL;
                end
            end
        end

        // a finished code returns to idle
        if (emit)
        begin
            phase_next      = PH_IDLE;
            zero_run_next   = 7'd0;
            length_msb_next = 8'd0;
            tail_left_next  = 8'd0;
            acc_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_mode_reg  <= egd_pkg::MODE_GAMMA;
            max_bits_reg   <= egd_pkg::MAX_BITS_RESET;
            s1_valid_reg   <= 1'b0;
            s1_bit_reg     <= 1'b0;
            phase_reg      <= PH_IDLE;
            zero_run_reg   <= 7'd0;
            length_msb_reg <= 8'd0;
            tail_left_reg  <= 8'd0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            value_reg      <= '0;
            status_reg     <= egd_pkg::ST_OK;
        end
        else
        begin
            // input register
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_bit_reg   <= code_bit;
            end
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            // decode state; a config write aborts the code in progress
            if (cfg_we)
            begin
                if (cfg_index == egd_pkg::CFG_CODE_MODE)
                    code_mode_reg <= cfg_data[1:0];
                else
                    max_bits_reg <= cfg_data;
                phase_reg      <= PH_IDLE;
                zero_run_reg   <= 7'd0;
                length_msb_reg <= 8'd0;
                tail_left_reg  <= 8'd0;
                acc_reg        <= '0;
            end
            else if (s1_fire)
            begin
                phase_reg      <= phase_next;
                zero_run_reg   <= zero_run_next;
                length_msb_reg <= length_msb_next;
                tail_left_reg  <= tail_left_next;
                acc_reg        <= acc_next;
            end

            // result register
            if (s1_fire && emit)
            begin
                out_valid_reg <= 1'b1;
                value_reg     <= (emit_st == egd_pkg::ST_TOO_LARGE) ? '0 : emit_val;
                status_reg    <= emit_st;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
